// ===== rtl/core/assert_macros.svh =====
// assertion helpers for the rtl, clocked on clk and quiet while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen out of reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/rra_pkg.sv =====
package rra_pkg;

  localparam int MAX_RING_DEF = 32;
  localparam int CFG_W        = 6;
  localparam int WHO_W        = 5;
  localparam int TICK_W       = 32;
  localparam int TOT_W        = 48;
  localparam int CNT_W        = 32;
  localparam int JOB_IDX_W    = 8;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [CFG_W-1:0] RING_RESET = 6'd5;

  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;
  localparam logic [1:0] OP_STATS   = 2'd3;

  localparam logic [2:0] KIND_GRANTED  = 3'd0;
  localparam logic [2:0] KIND_WAITING  = 3'd1;
  localparam logic [2:0] KIND_RELEASED = 3'd2;
  localparam logic [2:0] KIND_STATS    = 3'd3;
  localparam logic [2:0] KIND_ERROR    = 3'd4;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [WHO_W-1:0] requester;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [WHO_W-1:0]  who;
    logic [TICK_W-1:0] wait_ticks;
    logic [TOT_W-1:0]  total_wait;
    logic [CNT_W-1:0]  grant_count;
    logic              last;
  } out_item_t;

  // one result to be carried out by the back end
  typedef struct packed {
    logic [2:0]           kind;
    logic [JOB_IDX_W-1:0] idx;
    logic [TICK_W-1:0]    wait_ticks;
    logic                 last;
  } job_t;

endpackage

// ===== rtl/core/ring_resource_arbiter.sv =====
// ring resource arbiter: requesters around a ring share resources with both
// neighbours; each one thinks, waits hungry or eats.
// input: a transaction is taken on a rising edge with start high and busy low.
//   request, release and statistics queries address one requester; a tick
//   advances the time counter and produces no result.
// output: each result sits on out_item for one cycle with out_valid high;
//   last marks the final result of a transaction. A request, query or bad
//   transaction gives one result, a release gives one to three.
// config: cfg_we writes the ring size from cfg_wdata; the user must write it only
//   while idle; the block itself does not enforce this.
// results go through the job queue, stage one and the output register, one a cycle.
// throughput: requests, ticks and queries go one per cycle while the queue has room;
//   a release holds busy through its decision and grant states while the front end
//   walks the left and right retries and reads the hunger start times from its ram.
// a four-entry job queue splits the front end from the statistics pipeline;
//   busy is also raised while that queue is full.
// reset: every requester thinking, time and all totals zero, ring size 5.
// the receiver cannot stall, so results leave at the rate they are made.
`include "assert_macros.svh"

module ring_resource_arbiter #(
  parameter int MAX_RING = rra_pkg::MAX_RING_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  rra_pkg::in_item_t         in_item,
  output logic                      busy,
  output logic                      out_valid,
  output rra_pkg::out_item_t        out_item,
  input  logic                      cfg_we,
  input  logic [rra_pkg::CFG_W-1:0] cfg_wdata
);
  import rra_pkg::*;

  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      return CFG_W'(1);
    end
    if (int'(v) > MAX_RING) begin
      return CFG_W'(MAX_RING);
    end
    return v;
  endfunction

  logic [CFG_W-1:0] eff_n_r;
  logic             q_push, q_pop, q_full, q_empty;
  job_t             q_job, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_n_r <= clamp_size(RING_RESET);
    end else if (cfg_we) begin
      eff_n_r <= clamp_size(cfg_wdata);
    end
  end

  rra_front #(
    .MAX_RING(MAX_RING)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .eff_n  (eff_n_r),
    .start  (start),
    .in_item(in_item),
    .busy   (busy),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (q_job)
  );

  rra_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_job),
    .pop  (q_pop),
    .rdata(q_head),
    .full (q_full),
    .empty(q_empty)
  );

  rra_back #(
    .MAX_RING(MAX_RING)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  `ASSERT_CLK(a_full_busy, q_full |-> busy, "job queue full while front end takes input")
  `ASSERT_NEVER(a_no_overflow, q_push && q_full, "push into a full job queue")
  `ASSERT_NEVER(a_no_underflow, q_pop && q_empty, "pop from an empty job queue")
endmodule

// ===== rtl/core/rra_ram.sv =====
module rra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== rtl/core/rra_queue.sv =====
module rra_queue #(
  parameter int DEPTH = rra_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rra_pkg::job_t  wdata,
  input  logic           pop,
  output rra_pkg::job_t  rdata,
  output logic           full,
  output logic           empty
);
  import rra_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end
endmodule

// ===== rtl/core/rra_front.sv =====
module rra_front #(
  parameter int MAX_RING = rra_pkg::MAX_RING_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [rra_pkg::CFG_W-1:0] eff_n,
  input  logic                      start,
  input  rra_pkg::in_item_t         in_item,
  output logic                      busy,
  input  logic                      q_full,
  output logic                      q_push,
  output rra_pkg::job_t             q_job
);
  import rra_pkg::*;

  localparam int IW = $clog2(MAX_RING);
  localparam int NW = ((IW > CFG_W) ? IW : CFG_W) + 1;

  typedef enum logic [1:0] {ST_IDLE, ST_REL_DEC, ST_REL_GL, ST_REL_GR} state_t;

  function automatic logic [IW-1:0] left_of(input logic [IW-1:0] i,
                                            input logic [CFG_W-1:0] n);
    logic [NW-1:0] t;
    t = NW'(n) - NW'(1);
    return (i == '0) ? IW'(t) : i - IW'(1);
  endfunction

  function automatic logic [IW-1:0] right_of(input logic [IW-1:0] i,
                                             input logic [CFG_W-1:0] n);
    logic [NW-1:0] t;
    t = NW'(i) + NW'(1);
    return (t == NW'(n)) ? '0 : IW'(t);
  endfunction

  function automatic job_t mk_job(input logic [2:0] kind, input logic [JOB_IDX_W-1:0] i,
                                  input logic [TICK_W-1:0] w, input logic lst);
    job_t j;
    j.kind       = kind;
    j.idx        = i;
    j.wait_ticks = w;
    j.last       = lst;
    return j;
  endfunction

  state_t              state_r, state_nxt;
  logic [MAX_RING-1:0] hung_r, hung_nxt;
  logic [MAX_RING-1:0] eat_r, eat_nxt;
  logic [TICK_W-1:0]   now_r, now_nxt;
  logic [IW-1:0]       rel_r, rel_nxt;
  logic [IW-1:0]       lft_r, lft_nxt;
  logic [IW-1:0]       rgt_r, rgt_nxt;
  logic                gr_r, gr_nxt;

  logic                acc;
  logic                in_range;
  logic [JOB_IDX_W-1:0] rq;
  logic [IW-1:0]       ri, ri_l, ri_r;
  logic [IW-1:0]       ll, rr;
  logic                gl, gr;
  logic                hs_we;
  logic [IW-1:0]       hs_raddr;
  logic [TICK_W-1:0]   hs_rdata;
  logic [TICK_W-1:0]   wait_val;

  assign busy     = (state_r != ST_IDLE) || q_full;
  assign acc      = start && !busy;
  assign in_range = ({1'b0, in_item.requester} < (WHO_W + 1)'(eff_n));
  // full requester number, so a bad transaction reports it untruncated
  assign rq       = JOB_IDX_W'(in_item.requester);
  assign ri       = IW'(in_item.requester);
  assign ri_l     = left_of(ri, eff_n);
  assign ri_r     = right_of(ri, eff_n);

  // retry decisions after a release; right of the left neighbour is the released one
  assign ll = left_of(lft_r, eff_n);
  assign rr = right_of(rgt_r, eff_n);
  assign gl = hung_r[lft_r] && !eat_r[ll];
  assign gr = hung_r[rgt_r] && !eat_r[rr] && !(gl && ((rgt_r == lft_r) || (rr == lft_r)));

  assign wait_val = now_r - hs_rdata;

  rra_ram #(
    .WIDTH(TICK_W),
    .DEPTH(MAX_RING)
  ) u_hs_ram (
    .clk  (clk),
    .we   (hs_we),
    .waddr(ri),
    .wdata(now_r),
    .raddr(hs_raddr),
    .rdata(hs_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    hung_nxt  = hung_r;
    eat_nxt   = eat_r;
    now_nxt   = now_r;
    rel_nxt   = rel_r;
    lft_nxt   = lft_r;
    rgt_nxt   = rgt_r;
    gr_nxt    = gr_r;
    q_push    = 1'b0;
    q_job     = '0;
    hs_we     = 1'b0;
    hs_raddr  = lft_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (in_item.opcode)
            OP_TICK: begin
              now_nxt = now_r + TICK_W'(1);
            end
            OP_REQUEST: begin
              q_push = 1'b1;
              if (!in_range || hung_r[ri] || eat_r[ri]) begin
                q_job = mk_job(KIND_ERROR, rq, '0, 1'b1);
              end else begin
                hs_we = 1'b1;
                if (!eat_r[ri_l] && !eat_r[ri_r]) begin
                  eat_nxt[ri] = 1'b1;
                  q_job       = mk_job(KIND_GRANTED, rq, '0, 1'b1);
                end else begin
                  hung_nxt[ri] = 1'b1;
                  q_job        = mk_job(KIND_WAITING, rq, '0, 1'b1);
                end
              end
            end
            OP_RELEASE: begin
              if (!in_range || !eat_r[ri]) begin
                q_push = 1'b1;
                q_job  = mk_job(KIND_ERROR, rq, '0, 1'b1);
              end else begin
                eat_nxt[ri] = 1'b0;
                rel_nxt     = ri;
                lft_nxt     = ri_l;
                rgt_nxt     = ri_r;
                state_nxt   = ST_REL_DEC;
              end
            end
            default: begin
              q_push = 1'b1;
              if (!in_range) begin
                q_job = mk_job(KIND_ERROR, rq, '0, 1'b1);
              end else begin
                q_job = mk_job(KIND_STATS, rq, '0, 1'b1);
              end
            end
          endcase
        end
      end
      ST_REL_DEC: begin
        hs_raddr = gl ? lft_r : rgt_r;
        if (!q_full) begin
          q_push = 1'b1;
          q_job  = mk_job(KIND_RELEASED, JOB_IDX_W'(rel_r), '0, !gl && !gr);
          if (gl) begin
            hung_nxt[lft_r] = 1'b0;
            eat_nxt[lft_r]  = 1'b1;
          end
          if (gr) begin
            hung_nxt[rgt_r] = 1'b0;
            eat_nxt[rgt_r]  = 1'b1;
          end
          gr_nxt    = gr;
          state_nxt = gl ? ST_REL_GL : (gr ? ST_REL_GR : ST_IDLE);
        end
      end
      ST_REL_GL: begin
        // keep the left address while stalled so the read data holds
        hs_raddr = q_full ? lft_r : rgt_r;
        if (!q_full) begin
          q_push    = 1'b1;
          q_job     = mk_job(KIND_GRANTED, JOB_IDX_W'(lft_r), wait_val, !gr_r);
          state_nxt = gr_r ? ST_REL_GR : ST_IDLE;
        end
      end
      ST_REL_GR: begin
        hs_raddr = rgt_r;
        if (!q_full) begin
          q_push    = 1'b1;
          q_job     = mk_job(KIND_GRANTED, JOB_IDX_W'(rgt_r), wait_val, 1'b1);
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      hung_r  <= '0;
      eat_r   <= '0;
      now_r   <= '0;
    end else begin
      state_r <= state_nxt;
      hung_r  <= hung_nxt;
      eat_r   <= eat_nxt;
      now_r   <= now_nxt;
    end
    rel_r <= rel_nxt;
    lft_r <= lft_nxt;
    rgt_r <= rgt_nxt;
    gr_r  <= gr_nxt;
  end
endmodule

// ===== rtl/core/rra_back.sv =====
module rra_back #(
  parameter int MAX_RING = rra_pkg::MAX_RING_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  rra_pkg::job_t      q_head,
  output logic               q_pop,
  output logic               out_valid,
  output rra_pkg::out_item_t out_item
);
  import rra_pkg::*;

  localparam int IW = $clog2(MAX_RING);
  localparam int SW = TOT_W + CNT_W;

  logic                s1_vld_r;
  job_t                s1_job_r;
  logic [MAX_RING-1:0] vld_r;
  logic                bypass_r, bypass_nxt;
  logic [SW-1:0]       hold_r;
  logic                out_valid_r;
  out_item_t           out_item_r, out_item_nxt;

  logic [IW-1:0]       sidx;
  logic [SW-1:0]       ram_rdata;
  logic [SW-1:0]       cur;
  logic [TOT_W-1:0]    cur_tot, new_tot;
  logic [CNT_W-1:0]    cur_cnt, new_cnt;
  logic [TOT_W:0]      sum;
  logic                is_grant, is_stats;

  assign q_pop    = !q_empty;
  assign sidx     = IW'(s1_job_r.idx);
  assign is_grant = s1_vld_r && (s1_job_r.kind == KIND_GRANTED);
  assign is_stats = s1_job_r.kind == KIND_STATS;

  rra_ram #(
    .WIDTH(SW),
    .DEPTH(MAX_RING)
  ) u_stat_ram (
    .clk  (clk),
    .we   (is_grant),
    .waddr(sidx),
    .wdata({new_tot, new_cnt}),
    .raddr(IW'(q_head.idx)),
    .rdata(ram_rdata)
  );

  // entries never granted read as zero; last cycle's write is forwarded
  assign cur     = bypass_r ? hold_r : (vld_r[sidx] ? ram_rdata : '0);
  assign cur_tot = cur[SW-1:CNT_W];
  assign cur_cnt = cur[CNT_W-1:0];
  assign sum     = {1'b0, cur_tot} + (TOT_W + 1)'(s1_job_r.wait_ticks);
  assign new_tot = sum[TOT_W] ? '1 : sum[TOT_W-1:0];
  assign new_cnt = (&cur_cnt) ? cur_cnt : cur_cnt + CNT_W'(1);

  assign bypass_nxt = q_pop && is_grant && (q_head.idx == s1_job_r.idx);

  always_comb begin
    out_item_nxt             = '0;
    out_item_nxt.kind        = s1_job_r.kind;
    out_item_nxt.who         = WHO_W'(s1_job_r.idx);
    out_item_nxt.last        = s1_job_r.last;
    if (is_grant) begin
      out_item_nxt.wait_ticks  = s1_job_r.wait_ticks;
      out_item_nxt.total_wait  = new_tot;
      out_item_nxt.grant_count = new_cnt;
    end else if (is_stats) begin
      out_item_nxt.total_wait  = cur_tot;
      out_item_nxt.grant_count = cur_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      vld_r       <= '0;
      bypass_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r    <= q_pop;
      bypass_r    <= bypass_nxt;
      out_valid_r <= s1_vld_r;
      if (is_grant) begin
        vld_r[sidx] <= 1'b1;
      end
    end
    s1_job_r   <= q_head;
    hold_r     <= {new_tot, new_cnt};
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
endmodule
